### rtl/core/pdde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdde_pkg
// Shared types and constants of the pseudodecimal double encoder.
// ----------------------------------------------------------------------------
package pdde_pkg;

  localparam int unsigned MaxExp    = 22;
  localparam logic [4:0]  EXC_CODE  = 5'd23;
  localparam logic [4:0]  LIMIT_RST = 5'd31;

  // Engine status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } eng_status_t;

  // One finished result
  typedef struct packed {
    logic [4:0]  exponent_code;
    logic [30:0] digits;
    logic        is_exception;
  } result_t;

  // binary64 patterns of the doubles nearest 10^-e
  function automatic logic [63:0] frac_of_ten(input logic [4:0] e);
    logic [63:0] c;
    case (e)
      5'd0:    c = 64'h3FF0000000000000;
      5'd1:    c = 64'h3FB999999999999A;
      5'd2:    c = 64'h3F847AE147AE147B;
      5'd3:    c = 64'h3F50624DD2F1A9FC;
      5'd4:    c = 64'h3F1A36E2EB1C432D;
      5'd5:    c = 64'h3EE4F8B588E368F1;
      5'd6:    c = 64'h3EB0C6F7A0B5ED8D;
      5'd7:    c = 64'h3E7AD7F29ABCAF48;
      5'd8:    c = 64'h3E45798EE2308C3A;
      5'd9:    c = 64'h3E112E0BE826D695;
      5'd10:   c = 64'h3DDB7CDFD9D7BDBB;
      5'd11:   c = 64'h3DA5FD7FE1796495;
      5'd12:   c = 64'h3D719799812DEA11;
      5'd13:   c = 64'h3D3C25C268497682;
      5'd14:   c = 64'h3D06849B86A12B9B;
      5'd15:   c = 64'h3CD203AF9EE75616;
      5'd16:   c = 64'h3C9CD2B297D889BC;
      5'd17:   c = 64'h3C670EF54646D497;
      5'd18:   c = 64'h3C32725DD1D243AC;
      5'd19:   c = 64'h3BFD83C94FB6D2AC;
      5'd20:   c = 64'h3BC79CA10C924223;
      5'd21:   c = 64'h3B92E3B40A0E9B4F;
      5'd22:   c = 64'h3B5E392010175EE6;
      default: c = 64'h3FF0000000000000;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/pdde_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdde_engine
// Trial sequencer: per exponent one radix-2 divide, quotient rounding, a
// two-pass multiply on one shared multiplier, product rounding and compare.
// ----------------------------------------------------------------------------
module pdde_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           value_bits,
  input  logic [4:0]            limit,
  input  logic                  res_take,
  output pdde_pkg::eng_status_t status,
  output pdde_pkg::result_t     result
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_QRND  = 3'd3;
  localparam logic [2:0] ST_MUL1  = 3'd4;
  localparam logic [2:0] ST_MUL2  = 3'd5;
  localparam logic [2:0] ST_BACK  = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  localparam logic [5:0] DivSteps = 6'd54;

  logic [2:0]  state_r, state_nxt;
  logic [63:0] val_r, val_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [54:0] rem_r, rem_nxt;
  logic [53:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        adj_r, adj_nxt;
  logic [30:0] n_r, n_nxt;
  logic [83:0] prod_r, prod_nxt;
  pdde_pkg::result_t res_r, res_nxt;

  // operand fields
  logic [63:0] cbits;
  logic [10:0] evb, ecb;
  logic [52:0] mv, mc;
  logic signed [12:0] diff;

  assign cbits = pdde_pkg::frac_of_ten(idx_r);
  assign evb   = val_r[62:52];
  assign ecb   = cbits[62:52];
  assign mv    = {1'b1, val_r[51:0]};
  assign mc    = {1'b1, cbits[51:0]};
  assign diff  = $signed({2'b00, evb}) - $signed({2'b00, ecb});

  // divider step
  logic        ge;
  logic [54:0] rsub;
  assign ge   = rem_r >= {2'b00, mc};
  assign rsub = rem_r - {2'b00, mc};

  // quotient rounding and conversion to integer
  logic [52:0] qm_raw;
  logic        q_up;
  logic [53:0] q_sum;
  logic [52:0] qm;
  logic signed [12:0] qexp, sfull;
  logic [5:0]  sh_q;
  logic [52:0] q_int, q_half;
  logic [31:0] n32;
  logic        q_ok;

  assign qm_raw = quo_r[53:1];
  assign q_up  = quo_r[0] & ((|rem_r) | qm_raw[0]);
  assign q_sum = {1'b0, qm_raw} + {53'd0, q_up};
  assign qm    = q_sum[53] ? q_sum[53:1] : q_sum[52:0];
  assign qexp  = diff - $signed({12'd0, adj_r}) + $signed({12'd0, q_sum[53]});
  assign sfull = 13'sd52 - qexp;
  assign sh_q  = sfull[5:0];
  assign q_int  = qm >> sh_q;
  assign q_half = qm >> (sh_q - 6'd1);
  assign n32   = q_int[31:0] + {31'd0, q_half[0]};
  assign q_ok  = (qexp >= -13'sd1) && (qexp <= 13'sd30) && !n32[31] && (n32 != 32'd0);

  // shared multiplier, low then high half of the constant
  logic [26:0] mop_b;
  logic [57:0] mprod;
  assign mop_b = (state_r == ST_MUL1) ? mc[26:0] : {1'b0, mc[52:27]};
  assign mprod = {27'd0, n_r} * {31'd0, mop_b};

  // product normalize, round and compare
  logic [4:0]  nlen;
  logic [6:0]  top_idx;
  logic [4:0]  sh_p;
  logic [83:0] p_shift;
  logic [31:0] p_mask, p_rem, p_half;
  logic        p_up;
  logic [53:0] p_sum;
  logic [51:0] p_frac;
  logic [11:0] p_exp;
  logic [63:0] back;
  logic        match;

  always_comb begin
    nlen = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (n_r[i]) nlen = 5'(i + 1);
    end
  end

  assign top_idx = {2'b00, nlen} + 7'd52;
  assign sh_p    = prod_r[top_idx] ? nlen : nlen - 5'd1;
  assign p_shift = prod_r >> sh_p;
  assign p_mask  = (32'd1 << sh_p) - 32'd1;
  assign p_rem   = prod_r[31:0] & p_mask;
  assign p_half  = (sh_p == 5'd0) ? 32'd0 : (32'd1 << (sh_p - 5'd1));
  assign p_up    = (sh_p != 5'd0) &&
                   ((p_rem > p_half) || ((p_rem == p_half) && p_shift[0]));
  assign p_sum   = {1'b0, p_shift[52:0]} + {53'd0, p_up};
  assign p_frac  = p_sum[53] ? 52'd0 : p_sum[51:0];
  assign p_exp   = {1'b0, ecb} + {7'd0, sh_p} + {11'd0, p_sum[53]};
  assign back    = {1'b0, p_exp[10:0], p_frac};
  assign match   = (back == val_r) && (nlen <= limit);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    adj_nxt   = adj_r;
    n_nxt     = n_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          val_nxt = value_bits;
          idx_nxt = 5'd0;
          res_nxt.exponent_code = pdde_pkg::EXC_CODE;
          res_nxt.digits        = 31'd0;
          res_nxt.is_exception  = 1'b1;
          if (value_bits == 64'd0) begin
            // positive zero is exact at exponent zero
            res_nxt.exponent_code = 5'd0;
            res_nxt.is_exception  = 1'b0;
            state_nxt = ST_FIN;
          end else if (value_bits[63] || value_bits[62:52] == 11'd0 ||
                       value_bits[62:52] == 11'h7FF) begin
            // negative, subnormal, NaN or infinite: no trial can pass
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        if (diff >= 13'sd32 || diff <= -13'sd3) begin
          // quotient far outside [0.5, 2^31)
          if (idx_r == 5'(pdde_pkg::MaxExp)) state_nxt = ST_FIN;
          else idx_nxt = idx_r + 5'd1;
        end else begin
          adj_nxt   = mv < mc;
          rem_nxt   = (mv < mc) ? {1'b0, mv, 1'b0} : {2'b00, mv};
          quo_nxt   = 54'd0;
          cnt_nxt   = 6'd0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt = {quo_r[52:0], ge};
        rem_nxt = ge ? {rsub[53:0], 1'b0} : {rem_r[53:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DivSteps - 6'd1) state_nxt = ST_QRND;
      end
      ST_QRND: begin
        if (q_ok) begin
          n_nxt     = n32[30:0];
          state_nxt = ST_MUL1;
        end else if (idx_r == 5'(pdde_pkg::MaxExp)) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 5'd1;
          state_nxt = ST_SETUP;
        end
      end
      ST_MUL1: begin
        prod_nxt  = {26'd0, mprod};
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod_nxt  = prod_r + ({26'd0, mprod} << 27);
        state_nxt = ST_BACK;
      end
      ST_BACK: begin
        if (match) begin
          res_nxt.exponent_code = idx_r;
          res_nxt.digits        = n_r;
          res_nxt.is_exception  = 1'b0;
          state_nxt = ST_FIN;
        end else if (idx_r == 5'(pdde_pkg::MaxExp)) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 5'd1;
          state_nxt = ST_SETUP;
        end
      end
      ST_FIN: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    adj_r  <= adj_nxt;
    n_r    <= n_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign status.idle = (state_r == ST_IDLE);
  assign status.done = (state_r == ST_FIN);
  assign result      = res_r;

endmodule

### rtl/core/pseudodecimal_double_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pseudodecimal_double_encoder_top
// Encodes one binary64 value as a decimal exponent and integer digits.
// ----------------------------------------------------------------------------
// One value is worked at a time. Zero, negative, subnormal, NaN and infinite
// inputs finish without any trial. Otherwise exponents 0..22 are tried in
// turn: a trial whose quotient is clearly out of range ends after setup, a
// full trial runs setup, 54 radix-2 divider steps, a quotient round, 2 passes
// of the shared 31x27 multiplier, and a round and compare. A result sits in
// an output register, so the next value is taken while it waits.
// ----------------------------------------------------------------------------
module pseudodecimal_double_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_exponent_code,
  output logic [30:0] out_digits,
  output logic        out_is_exception,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] limit_r;
  logic       out_valid_r;
  pdde_pkg::result_t out_r;
  pdde_pkg::eng_status_t status;
  pdde_pkg::result_t     result;
  logic res_take;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? {27'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= pdde_pkg::LIMIT_RST;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      limit_r <= pwdata[4:0];
    end
  end

  assign in_ready = status.idle;
  assign res_take = status.done && (!out_valid_r || out_ready);

  pdde_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_valid && in_ready),
    .value_bits (in_value_bits),
    .limit      (limit_r),
    .res_take   (res_take),
    .status     (status),
    .result     (result)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) out_r <= result;
  end

  assign out_valid         = out_valid_r;
  assign out_exponent_code = out_r.exponent_code;
  assign out_digits        = out_r.digits;
  assign out_is_exception  = out_r.is_exception;

endmodule
